@@ design/score_normalize_prior_bias_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the score normalisation block
// Concurrent checks on the block clock, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef SCORE_NORMALIZE_PRIOR_BIAS_ASSERT_SVH
`define SCORE_NORMALIZE_PRIOR_BIAS_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SNP_ASSERT_HOLDS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("invariant violated");

`define SNP_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication violated");

`define SNP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`else

`define SNP_ASSERT_HOLDS(label, expr)
`define SNP_ASSERT_IMPLIES(label, ante, cons)
`define SNP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ design/snp_pkg.sv @@
// ---------------------------------------------------------------------------
// snp_pkg
// Shared types and constants of the score normalisation block.
// ---------------------------------------------------------------------------
package snp_pkg;

   localparam int MAX_LENGTH  = 1024;
   localparam int SCORE_WIDTH = 16;
   localparam int ADDR_W      = 10;
   localparam int COUNT_W     = 11;
   localparam int TABLE_W     = 3 * SCORE_WIDTH;
   localparam int FIFO_DEPTH  = 2;
   localparam int DIV_STEPS   = 35;
   localparam int ROOT_STEPS  = 27;

   typedef enum logic [1:0] {
      CMD_LOAD = 2'd0,
      CMD_PUSH = 2'd1,
      CMD_READ = 2'd2
   } cmd_type;

   localparam logic [1:0] CSR_NORMALIZE = 2'd0;
   localparam logic [1:0] CSR_PRIOR     = 2'd1;
   localparam logic [1:0] CSR_LENGTH    = 2'd2;

   typedef struct packed {
      cmd_type     cmd;
      logic [9:0]  index;
      logic [15:0] score;
      logic [15:0] offset_value;
      logic [15:0] scale_value;
      logic [15:0] bias_value;
   } item_type;

   typedef struct packed {
      logic        normalize;
      logic        prior;
      logic [10:0] length;     // effective length, 1 .. MAX_LENGTH
   } cfg_type;

   typedef enum logic {
      AR_DIV,
      AR_ROOT
   } arith_op_type;

   typedef struct packed {
      logic         start;
      arith_op_type op;
      logic [53:0]  operand;   // dividend sits in the top 35 bits
      logic [26:0]  divisor;
   } arith_req_type;

   typedef struct packed {
      logic        done;
      logic [34:0] result;
   } arith_rsp_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_FIN_MUL,
      BK_FIN_VAR,
      BK_MEAN_GO,
      BK_MEAN_WAIT,
      BK_ROOT_GO,
      BK_ROOT_WAIT,
      BK_INV_GO,
      BK_INV_WAIT,
      BK_RD_MUL1,
      BK_RD_ADD,
      BK_RD_MUL2,
      BK_RD_OUT
   } back_state_type;

endpackage

@@ design/snp_ram.sv @@
// ---------------------------------------------------------------------------
// snp_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module snp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/snp_front.sv @@
// ---------------------------------------------------------------------------
// snp_front
// Accepts request transfers, drops the reserved command and queues the rest.
// ---------------------------------------------------------------------------
`include "score_normalize_prior_bias_assert.svh"

module snp_front import snp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,
   input  logic [1:0]  req_tuser,
   output logic        item_valid,
   output item_type    item,
   input  logic        item_take
);

   item_type   q_ff [FIFO_DEPTH];
   item_type   q_in;
   logic [0:0] wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       accept, keep, push_q;

   assign req_tready = (count_ff != 2'(FIFO_DEPTH));
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      q_in.index        = req_tdata[9:0];
      q_in.score        = req_tdata[25:10];
      q_in.offset_value = req_tdata[41:26];
      q_in.scale_value  = req_tdata[57:42];
      q_in.bias_value   = req_tdata[73:58];
      q_in.cmd          = CMD_LOAD;
      keep              = 1'b1;
      case (req_tuser)
         CMD_LOAD: q_in.cmd = CMD_LOAD;
         CMD_PUSH: q_in.cmd = CMD_PUSH;
         CMD_READ: q_in.cmd = CMD_READ;
         default:  keep     = 1'b0;   // drop the reserved code
      endcase
   end

   assign push_q     = accept & keep;
   assign item_valid = (count_ff != 2'd0);
   assign item       = q_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push_q && !item_take) begin
         count_in = count_ff + 2'd1;
      end else if (!push_q && item_take) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push_q) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (item_take) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_q) begin
         q_ff[wr_ptr_ff] <= q_in;
      end
   end

   `SNP_ASSERT_IMPLIES(a_no_take_when_empty, item_take, count_ff != 2'd0)
   `SNP_ASSERT_HOLDS(a_count_bound, count_ff <= 2'(FIFO_DEPTH))
   `SNP_ASSERT_IMPLIES(a_full_stalls, count_ff == 2'(FIFO_DEPTH), !req_tready)

endmodule

@@ design/snp_arith.sv @@
// ---------------------------------------------------------------------------
// snp_arith
// Shared iterative unit: restoring divide or integer square root,
// one quotient or root bit per cycle.
// ---------------------------------------------------------------------------
module snp_arith import snp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  arith_req_type arith_req,
   output arith_rsp_type arith_rsp
);

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [5:0]   cnt_ff, cnt_in;
   arith_op_type op_ff, op_in;
   logic [53:0]  a_ff, a_in;
   logic [30:0]  rem_ff, rem_in;
   logic [34:0]  q_ff, q_in;
   logic [26:0]  div_ff, div_in;
   logic [28:0]  dsh;
   logic [30:0]  rsh, trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      a_in    = a_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      div_in  = div_ff;
      dsh     = {rem_ff[27:0], a_ff[53]};
      rsh     = {rem_ff[28:0], a_ff[53:52]};
      trial   = {2'b00, q_ff[26:0], 2'b01};
      if (arith_req.start) begin
         busy_in = 1'b1;
         op_in   = arith_req.op;
         a_in    = arith_req.operand;
         div_in  = arith_req.divisor;
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = (arith_req.op == AR_DIV) ? 6'(DIV_STEPS) : 6'(ROOT_STEPS);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 6'd1;
         if (op_ff == AR_DIV) begin
            a_in = {a_ff[52:0], 1'b0};
            if (dsh >= {2'b00, div_ff}) begin
               rem_in = {2'b00, dsh - {2'b00, div_ff}};
               q_in   = {q_ff[33:0], 1'b1};
            end else begin
               rem_in = {2'b00, dsh};
               q_in   = {q_ff[33:0], 1'b0};
            end
         end else begin
            a_in = {a_ff[51:0], 2'b00};
            if (rsh >= trial) begin
               rem_in = rsh - trial;
               q_in   = {q_ff[33:0], 1'b1};
            end else begin
               rem_in = rsh;
               q_in   = {q_ff[33:0], 1'b0};
            end
         end
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      a_ff   <= a_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      div_ff <= div_in;
   end

   assign arith_rsp.done   = done_ff;
   assign arith_rsp.result = q_ff;

endmodule

@@ design/snp_back.sv @@
// ---------------------------------------------------------------------------
// snp_back
// Executes queued commands: table loads, score pushes with running sums,
// per-vector statistics and the read path (optional normalisation) with its output stage.
// ---------------------------------------------------------------------------
`include "score_normalize_prior_bias_assert.svh"

module snp_back import snp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          item_valid,
   input  item_type      item,
   output logic          item_take,
   output arith_req_type arith_req,
   input  arith_rsp_type arith_rsp,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output logic [15:0]   rsp_value,
   output logic [9:0]    rsp_index,
   output logic          rsp_last,
   output logic          rsp_status
);

   back_state_type     state_ff, state_in;
   logic [10:0]        elem_count_ff, elem_count_in;
   logic signed [26:0] sum_ff, sum_in;
   logic [40:0]        sq_ff, sq_in;
   logic [15:0]        mean_ff, mean_in;
   logic [31:0]        inv_ff, inv_in;
   logic               ready_ff, ready_in;
   logic [10:0]        ptr_ff, ptr_in;
   logic [10:0]        n_ff, n_in;

   logic [42:0]        nsq_lo_ff;
   logic [19:0]        nsq_hi_ff;
   logic [51:0]        s2_ff;
   logic [21:0]        nn_ff;
   logic [53:0]        w_ff;
   logic               mean_neg_ff, mean_neg_in;
   logic [26:0]        root_ff, root_in;
   logic [9:0]         idx_ff, idx_in;
   logic               last_ff, last_in;
   logic signed [49:0] prod1_ff;
   logic signed [31:0] acl_ff;
   logic signed [47:0] prod2_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_value_ff, rsp_value_in;
   logic [9:0]         rsp_index_ff, rsp_index_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_status_ff, rsp_status_in;

   logic               out_free;
   logic               score_we, tab_we, rd_en;
   logic [9:0]         score_waddr, rd_addr;
   logic [15:0]        score_rd;
   logic [TABLE_W-1:0] tab_rd;

   logic signed [15:0] push_x;
   logic signed [31:0] push_sq;
   logic [10:0]        base_count, next_count;
   logic signed [26:0] base_sum;
   logic [40:0]        base_sq;
   logic [25:0]        sum_mag;
   logic [51:0]        nsq, var_v;
   logic signed [28:0] mean_num;
   logic [28:0]        mean_mag;
   logic [11:0]        two_n;
   logic signed [16:0] diff;
   logic signed [49:0] prod1_in, round1;
   logic signed [33:0] t_v;
   logic signed [34:0] a_v;
   logic signed [31:0] acl_in;
   logic signed [47:0] prod2_in, round2;
   logic signed [39:0] p_v, v_v;
   logic signed [40:0] v2;
   logic [15:0]        sat_v;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign push_x   = $signed(item.score);
   assign push_sq  = push_x * push_x;
   assign sum_mag  = sum_ff[26] ? 26'(-sum_ff) : sum_ff[25:0];

   snp_ram #(.WIDTH(SCORE_WIDTH), .DEPTH(MAX_LENGTH)) u_score_ram (
      .clock   (clock),
      .wr_en   (score_we),
      .wr_addr (score_waddr),
      .wr_data (item.score),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (score_rd)
   );

   snp_ram #(.WIDTH(TABLE_W), .DEPTH(MAX_LENGTH)) u_table_ram (
      .clock   (clock),
      .wr_en   (tab_we),
      .wr_addr (item.index),
      .wr_data ({item.offset_value, item.scale_value, item.bias_value}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (tab_rd)
   );

   // read datapath
   always_comb begin
      diff     = $signed({score_rd[15], score_rd}) - $signed({mean_ff[15], mean_ff});
      prod1_in = diff * $signed({1'b0, inv_ff});
      round1   = prod1_ff + 50'sd32768;
      t_v      = round1[49:16];
      a_v      = $signed({t_v[33], t_v})
               + $signed({{19{tab_rd[47]}}, tab_rd[47:32]});
      if (a_v > 35'sd1073741824) begin
         acl_in = 32'sd1073741824;
      end else if (a_v < -35'sd1073741824) begin
         acl_in = -32'sd1073741824;
      end else begin
         acl_in = a_v[31:0];
      end
      prod2_in = acl_ff * $signed({{32{tab_rd[31]}}, tab_rd[31:16]});
      round2   = prod2_ff + 48'sd128;
      p_v      = round2[47:8];
      v_v      = cfg.normalize ? p_v : $signed({{24{score_rd[15]}}, score_rd});
      v2       = $signed({v_v[39], v_v})
               + (cfg.prior ? $signed({{25{tab_rd[15]}}, tab_rd[15:0]}) : 41'sd0);
      if (v2 > 41'sd32767) begin
         sat_v = 16'h7fff;
      end else if (v2 < -41'sd32768) begin
         sat_v = 16'h8000;
      end else begin
         sat_v = v2[15:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      elem_count_in = elem_count_ff;
      sum_in        = sum_ff;
      sq_in         = sq_ff;
      mean_in       = mean_ff;
      inv_in        = inv_ff;
      ready_in      = ready_ff;
      ptr_in        = ptr_ff;
      n_in          = n_ff;
      mean_neg_in   = mean_neg_ff;
      root_in       = root_ff;
      idx_in        = idx_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      item_take     = 1'b0;
      score_we      = 1'b0;
      tab_we        = 1'b0;
      rd_en         = 1'b0;
      arith_req     = '0;

      base_count  = ready_ff ? 11'd0 : elem_count_ff;
      base_sum    = ready_ff ? 27'sd0 : sum_ff;
      base_sq     = ready_ff ? 41'd0 : sq_ff;
      next_count  = base_count + 11'd1;
      score_waddr = base_count[9:0];
      rd_addr     = ptr_ff[10] ? 10'h3ff : ptr_ff[9:0];

      nsq      = 52'(nsq_lo_ff) + {nsq_hi_ff, 32'd0};
      var_v    = (nsq >= s2_ff) ? nsq - s2_ff : 52'd0;
      two_n    = {n_ff, 1'b0};
      mean_num = $signed({sum_ff[26], sum_ff, 1'b0}) + $signed({18'd0, n_ff});
      mean_mag = mean_num[28] ? 29'(-mean_num) : mean_num;

      case (state_ff)
         BK_IDLE: begin
            if (item_valid && (item.cmd != CMD_READ || out_free)) begin
               item_take = 1'b1;
               case (item.cmd)
                  CMD_LOAD: begin
                     tab_we = 1'b1;
                  end
                  CMD_PUSH: begin
                     score_we      = 1'b1;
                     elem_count_in = next_count;
                     sum_in        = base_sum + 27'(push_x);
                     sq_in         = base_sq + {9'd0, push_sq};
                     ready_in      = 1'b0;
                     if (ready_ff) begin
                        ptr_in = 11'd0;
                     end
                     if (next_count >= cfg.length) begin
                        n_in     = next_count;
                        state_in = BK_FIN_MUL;
                     end
                  end
                  CMD_READ: begin
                     if (!ready_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_value_in  = '0;
                        rsp_index_in  = '0;
                        rsp_last_in   = 1'b0;
                        rsp_status_in = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        idx_in   = rd_addr;
                        last_in  = ({1'b0, rd_addr} + 11'd1) >= cfg.length;
                        state_in = BK_RD_MUL1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         BK_FIN_MUL:  state_in = BK_FIN_VAR;
         BK_FIN_VAR:  state_in = BK_MEAN_GO;
         BK_MEAN_GO: begin
            arith_req.start   = 1'b1;
            arith_req.op      = AR_DIV;
            arith_req.operand = {35'(mean_mag) + (mean_num[28] ? 35'(two_n - 12'd1) : 35'd0),
                                 19'd0};
            arith_req.divisor = 27'(two_n);
            mean_neg_in       = mean_num[28];
            state_in          = BK_MEAN_WAIT;
         end
         BK_MEAN_WAIT: begin
            if (arith_rsp.done) begin
               mean_in  = mean_neg_ff ? 16'(-arith_rsp.result[15:0]) : arith_rsp.result[15:0];
               state_in = BK_ROOT_GO;
            end
         end
         BK_ROOT_GO: begin
            arith_req.start   = 1'b1;
            arith_req.op      = AR_ROOT;
            arith_req.operand = w_ff;
            state_in          = BK_ROOT_WAIT;
         end
         BK_ROOT_WAIT: begin
            if (arith_rsp.done) begin
               root_in  = (arith_rsp.result[26:0] == 27'd0) ? 27'd1 : arith_rsp.result[26:0];
               state_in = BK_INV_GO;
            end
         end
         BK_INV_GO: begin
            arith_req.start   = 1'b1;
            arith_req.op      = AR_DIV;
            arith_req.operand = {n_ff, 24'd0, 19'd0};
            arith_req.divisor = root_ff;
            state_in          = BK_INV_WAIT;
         end
         BK_INV_WAIT: begin
            if (arith_rsp.done) begin
               inv_in   = (arith_rsp.result[34:32] != 3'd0) ? 32'hffff_ffff
                                                             : arith_rsp.result[31:0];
               ready_in = 1'b1;
               ptr_in   = 11'd0;
               state_in = BK_IDLE;
            end
         end
         BK_RD_MUL1:  state_in = BK_RD_ADD;
         BK_RD_ADD:   state_in = BK_RD_MUL2;
         BK_RD_MUL2:  state_in = BK_RD_OUT;
         BK_RD_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = sat_v;
               rsp_index_in  = idx_ff;
               rsp_last_in   = last_ff;
               rsp_status_in = 1'b0;
               state_in      = BK_IDLE;
               if (last_ff) begin
                  elem_count_in = '0;
                  sum_in        = '0;
                  sq_in         = '0;
                  ready_in      = 1'b0;
                  ptr_in        = '0;
               end else begin
                  ptr_in = {1'b0, idx_ff} + 11'd1;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         elem_count_ff <= '0;
         sum_ff        <= '0;
         sq_ff         <= '0;
         mean_ff       <= '0;
         inv_ff        <= '0;
         ready_ff      <= 1'b0;
         ptr_ff        <= '0;
         n_ff          <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         elem_count_ff <= elem_count_in;
         sum_ff        <= sum_in;
         sq_ff         <= sq_in;
         mean_ff       <= mean_in;
         inv_ff        <= inv_in;
         ready_ff      <= ready_in;
         ptr_ff        <= ptr_in;
         n_ff          <= n_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nsq_lo_ff     <= n_ff * sq_ff[31:0];
      nsq_hi_ff     <= n_ff * sq_ff[40:32];
      s2_ff         <= sum_mag * sum_mag;
      nn_ff         <= n_ff * n_ff;
      w_ff          <= 54'(var_v) + 54'(nn_ff);
      mean_neg_ff   <= mean_neg_in;
      root_ff       <= root_in;
      idx_ff        <= idx_in;
      last_ff       <= last_in;
      prod1_ff      <= prod1_in;
      acl_ff        <= acl_in;
      prod2_ff      <= prod2_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_index  = rsp_index_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_status = rsp_status_ff;

   `SNP_ASSERT_HOLDS(a_ready_count, !ready_ff || (elem_count_ff == n_ff))
   `SNP_ASSERT_IMPLIES(a_error_payload, rsp_valid_ff && rsp_status_ff,
                       rsp_value_ff == 16'd0 && rsp_index_ff == 10'd0 && !rsp_last_ff)
   `SNP_ASSERT_NEXT(a_mean_to_root, state_ff == BK_MEAN_WAIT && arith_rsp.done,
                    state_ff == BK_ROOT_GO)

endmodule

@@ design/score_normalize_prior_bias.sv @@
// ---------------------------------------------------------------------------
// score_normalize_prior_bias
// Score vector post-processing: normalisation, per-element affine and prior.
// ---------------------------------------------------------------------------
// Load and push are done as they leave the queue head; a read passes from
// queue head to result register through RAM read and two multiplies.
// The vector's last push starts statistics work (three passes of the
// shared bit-serial divide/square-root unit) before reads run.
// A 2-entry queue decouples request acceptance from execution.
// Synchronous active-high reset clears control state and config registers.
module score_normalize_prior_bias import snp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // index, score, offset_value, scale_value, bias_value
   input  logic [1:0]  req_tuser,  // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // result_value, result_index
   output logic        rsp_tlast,
   output logic [0:0]  rsp_tuser,  // status
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata
);

   logic          normalize_ff, prior_ff;
   logic [10:0]   length_ff;
   cfg_type       cfg;
   logic          item_valid, item_take;
   item_type      item;
   arith_req_type arith_req;
   arith_rsp_type arith_rsp;
   logic [15:0]   rsp_value;
   logic [9:0]    rsp_index;

   always_ff @(posedge clock) begin
      if (reset) begin
         normalize_ff <= 1'b0;
         prior_ff     <= 1'b0;
         length_ff    <= 11'(MAX_LENGTH);
      end else if (csr_we) begin
         case (csr_index)
            CSR_NORMALIZE: normalize_ff <= csr_wdata[0];
            CSR_PRIOR:     prior_ff     <= csr_wdata[0];
            CSR_LENGTH:    length_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp the length to 1 .. MAX_LENGTH
   always_comb begin
      cfg.normalize = normalize_ff;
      cfg.prior     = prior_ff;
      if (length_ff == 11'd0) begin
         cfg.length = 11'd1;
      end else if (length_ff > 11'(MAX_LENGTH)) begin
         cfg.length = 11'(MAX_LENGTH);
      end else begin
         cfg.length = length_ff;
      end
   end

   snp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   snp_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .arith_req (arith_req),
      .arith_rsp (arith_rsp)
   );

   snp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .arith_req  (arith_req),
      .arith_rsp  (arith_rsp),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_value  (rsp_value),
      .rsp_index  (rsp_index),
      .rsp_last   (rsp_tlast),
      .rsp_status (rsp_tuser[0])
   );

   assign rsp_tdata = {6'd0, rsp_index, rsp_value};

endmodule

@@ tb/score_normalize_prior_bias_test.sv @@
// ---------------------------------------------------------------------------
// score_normalize_prior_bias_test
// Self-checking bench for the score normalisation block. A short directed
// table covers the error read, extremes, push-while-ready and the unused
// command. Random vectors then run under several register settings. Results
// not fixed by typed directed rows are compared with a fixed-point in-bench model.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module score_normalize_prior_bias_test;
   import snp_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 300;
   localparam int FILL_ENTRIES  = 64;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [9:0]  index;
      logic [15:0] score;
      logic [15:0] offset_value;
      logic [15:0] scale_value;
      logic [15:0] bias_value;
   } cmd_item_type;

   typedef struct packed {
      logic [15:0] value;
      logic [9:0]  index;
      logic        last;
      logic        status;
   } score_result_type;

   typedef struct packed {
      cmd_item_type     item;
      logic             typed;
      score_result_type want;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [10:0] csr_wdata = '0;

   score_normalize_prior_bias i_dut (.*);

   always #5 clock = ~clock;

   // model state
   logic signed [15:0] score_mem  [MAX_LENGTH];
   logic signed [15:0] offset_mem [MAX_LENGTH];
   logic signed [15:0] scale_mem  [MAX_LENGTH];
   logic signed [15:0] bias_mem   [MAX_LENGTH];
   int          elem_count;
   longint      sum_acc;
   longint      square_acc;
   longint      mean_q8;
   longint      inv_dev;
   bit          vec_ready;
   int          rd_ptr;
   bit          norm_on;
   bit          prior_on;
   int          length_reg;

   score_result_type expected_results[$];
   int          mismatches;
   int          received;
   int          accepted;
   int          burst_left;
   int          vectors_done;

   function automatic int live_length();
      if (length_reg == 0) return 1;
      if (length_reg > MAX_LENGTH) return MAX_LENGTH;
      return length_reg;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint round_q(input longint v, input int s);
      longint h;
      h = longint'(1) <<< (s - 1);
      return (v + h) >>> s;
   endfunction

   function automatic void clear_vector();
      elem_count = 0;
      sum_acc = 0;
      square_acc = 0;
      vec_ready = 0;
      rd_ptr = 0;
   endfunction

   function automatic void close_vector();
      longint unsigned n, mag, nsq, s2, var_q, root, inv;
      longint a, b, q;
      n = elem_count;
      mag = sum_acc < 0 ? -sum_acc : sum_acc;
      nsq = n * longint'(square_acc);
      s2 = mag * mag;
      var_q = nsq >= s2 ? nsq - s2 : 0;
      root = int_sqrt(var_q + n * n);
      if (root < 1) root = 1;
      inv = (64'd1 << 24) * n / root;
      if (inv > 64'hFFFF_FFFF) inv = 64'hFFFF_FFFF;
      a = 2 * sum_acc + longint'(n);
      b = 2 * longint'(n);
      q = a / b;
      if ((a % b) != 0 && a < 0) q = q - 1;
      mean_q8 = q;
      inv_dev = longint'(inv);
      vec_ready = 1;
      rd_ptr = 0;
   endfunction

   // advance the model by one accepted transfer; returns 1 if a result follows
   function automatic bit normalize_step(input cmd_item_type it,
                                         output score_result_type r);
      longint x, v, t, a, lim;
      int     idx;
      r = '0;
      if (it.cmd == CMD_LOAD) begin
         offset_mem[it.index] = it.offset_value;
         scale_mem[it.index]  = it.scale_value;
         bias_mem[it.index]   = it.bias_value;
         return 0;
      end
      if (it.cmd == CMD_PUSH) begin
         x = longint'($signed(it.score));
         if (vec_ready) clear_vector();
         if (elem_count < MAX_LENGTH) score_mem[elem_count] = it.score;
         sum_acc = sum_acc + x;
         square_acc = square_acc + x * x;
         elem_count++;
         if (elem_count >= live_length()) close_vector();
         return 0;
      end
      if (it.cmd == CMD_READ) begin
         if (!vec_ready) begin
            r.status = 1'b1;
            return 1;
         end
         idx = rd_ptr >= MAX_LENGTH ? MAX_LENGTH - 1 : rd_ptr;
         x = longint'(score_mem[idx]);
         v = x;
         if (norm_on) begin
            t = round_q((x - mean_q8) * inv_dev, 16);
            a = t + longint'(offset_mem[idx]);
            lim = longint'(1) <<< 30;
            if (a > lim) a = lim;
            if (a < -lim) a = -lim;
            v = round_q(a * longint'(scale_mem[idx]), 8);
         end
         if (prior_on) v = v + longint'(bias_mem[idx]);
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         r.value = v[15:0];
         r.index = idx[9:0];
         r.last = (idx + 1 >= live_length());
         if (r.last) begin
            clear_vector();
            vectors_done++;
         end else begin
            rd_ptr = idx + 1;
         end
         return 1;
      end
      return 0;
   endfunction

   // result side: rsp_tready follows a randomly chosen stall pattern
   int stall_mode = 0;
   int stall_phase = 0;
   always @(negedge clock) begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 1) == 1);
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= ((stall_phase % 7) < 4);
      endcase
   end

   always @(posedge clock) begin
      score_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.value  = rsp_tdata[15:0];
         got.index  = rsp_tdata[25:16];
         got.last   = rsp_tlast;
         got.status = rsp_tuser[0];
         received++;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result value=%0d index=%0d last=%0b status=%0b",
                        $signed(got.value), got.index, got.last, got.status);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch #%0d: want v=%0d i=%0d l=%0b s=%0b, got v=%0d i=%0d l=%0b s=%0b",
                           received, $signed(want.value), want.index, want.last,
                           want.status, $signed(got.value), got.index, got.last,
                           got.status);
            end
         end
      end
   end

   // called at a falling edge; returns at a falling edge after the transfer
   task automatic send_item(input cmd_item_type it, input bit typed,
                            input score_result_type want);
      score_result_type r;
      bit has;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.cmd;
      req_tdata  <= {6'b0, it.bias_value, it.scale_value, it.offset_value, it.score,
                     it.index};
      do @(posedge clock); while (!req_tready);
      accepted++;
      has = normalize_step(it, r);
      if (has) expected_results.insert(expected_results.size(), typed ? want : r);
      burst_left--;
      @(negedge clock);
   endtask

   task automatic send(input cmd_item_type it);
      send_item(it, 1'b0, '0);
   endtask

   // hold the input quiet until every result is back and the block has settled
   task automatic quiesce();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[10:0];
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      if (idx == CSR_NORMALIZE) norm_on = value[0];
      else if (idx == CSR_PRIOR) prior_on = value[0];
      else length_reg = int'(value[10:0]);
   endtask

   function automatic cmd_item_type mk(input logic [1:0] c, input logic [9:0] i,
                                       input logic [15:0] s, input logic [15:0] o,
                                       input logic [15:0] k, input logic [15:0] b);
      cmd_item_type it;
      it.cmd = c;
      it.index = i;
      it.score = s;
      it.offset_value = o;
      it.scale_value = k;
      it.bias_value = b;
      return it;
   endfunction

   function automatic logic [15:0] rand_score();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(0, 65535));
         default: return 16'($signed($urandom_range(0, 2047)) - 1024);
      endcase
   endfunction

   function automatic cmd_item_type rand_load();
      return mk(CMD_LOAD, 10'($urandom_range(0, 1023)), 16'($urandom_range(0, 65535)),
                rand_score(), 16'($signed($urandom_range(0, 1023)) - 512),
                rand_score());
   endfunction

   function automatic cmd_item_type read_item();
      return mk(CMD_READ, 10'($urandom_range(0, 1023)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)));
   endfunction

   function automatic cmd_item_type push_item(input logic [15:0] s);
      cmd_item_type it;
      it = read_item();
      it.cmd = CMD_PUSH;
      it.score = s;
      return it;
   endfunction

   // one vector with random content, with loads, stray commands and early
   // restarts mixed in
   task automatic run_vector();
      int n, k, stop_at;
      cmd_item_type it;
      n = live_length();
      for (k = 0; k < n; k++) begin
         if ($urandom_range(0, 9) == 0) send(rand_load());
         if ($urandom_range(0, 39) == 0 && !vec_ready) send(read_item());
         if ($urandom_range(0, 49) == 0) begin
            it = read_item();
            it.cmd = CMD_UNUSED;
            send(it);
         end
         send(push_item(rand_score()));
      end
      stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n) : n;
      for (k = 0; k < stop_at; k++) begin
         if ($urandom_range(0, 9) == 0) send(rand_load());
         send(read_item());
      end
      if ($urandom_range(0, 4) == 0) send(read_item());
   endtask

   directed_row_type directed[] = '{
      '{mk(CMD_READ, 10'd0, 16'd0, 16'd0, 16'd0, 16'd0), 1'b1, '{16'd0, 10'd0, 1'b0, 1'b1}},
      '{mk(CMD_LOAD, 10'd0, 16'd0, 16'h8000, 16'h8000, 16'h8000), 1'b0, '0},
      '{mk(CMD_LOAD, 10'd1, 16'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF), 1'b0, '0},
      '{mk(CMD_LOAD, 10'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0, '0},
      '{mk(CMD_PUSH, 10'd0, 16'h8000, 16'd0, 16'd0, 16'd0), 1'b0, '0},
      '{mk(CMD_READ, 10'd0, 16'd0, 16'd0, 16'd0, 16'd0), 1'b1, '{16'd0, 10'd0, 1'b0, 1'b1}},
      '{mk(CMD_PUSH, 10'd0, 16'h7FFF, 16'd0, 16'd0, 16'd0), 1'b0, '0},
      '{mk(CMD_READ, 10'd0, 16'd0, 16'd0, 16'd0, 16'd0), 1'b1, '{16'h8000, 10'd0, 1'b0, 1'b0}},
      '{mk(CMD_READ, 10'd0, 16'd0, 16'd0, 16'd0, 16'd0), 1'b1, '{16'h7FFF, 10'd1, 1'b1, 1'b0}},
      '{mk(CMD_READ, 10'd0, 16'd0, 16'd0, 16'd0, 16'd0), 1'b1, '{16'd0, 10'd0, 1'b0, 1'b1}},
      '{mk(CMD_UNUSED, 10'h3FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0, '0},
      '{mk(CMD_PUSH, 10'd0, 16'd1, 16'd0, 16'd0, 16'd0), 1'b0, '0},
      '{mk(CMD_PUSH, 10'd0, 16'd1, 16'd0, 16'd0, 16'd0), 1'b0, '0},
      '{mk(CMD_PUSH, 10'd0, 16'd5, 16'd0, 16'd0, 16'd0), 1'b0, '0},
      '{mk(CMD_PUSH, 10'd0, 16'd7, 16'd0, 16'd0, 16'd0), 1'b0, '0},
      '{mk(CMD_READ, 10'd0, 16'd0, 16'd0, 16'd0, 16'd0), 1'b1, '{16'd5, 10'd0, 1'b0, 1'b0}},
      '{mk(CMD_READ, 10'd0, 16'd0, 16'd0, 16'd0, 16'd0), 1'b1, '{16'd7, 10'd1, 1'b1, 1'b0}}
   };

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int phase, v, nvec, k;
      int lengths[8] = '{1, 0, 5, 16, 48, 3, 64, 2};
      int wait_cycles;
      mismatches = 0;
      received = 0;
      accepted = 0;
      burst_left = 0;
      vectors_done = 0;
      clear_vector();
      mean_q8 = 0;
      inv_dev = 0;
      norm_on = 0;
      prior_on = 0;
      length_reg = 1024;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_reg(CSR_NORMALIZE, 0);
      write_reg(CSR_PRIOR, 0);
      write_reg(CSR_LENGTH, 2);
      foreach (directed[row])
         send_item(directed[row].item, directed[row].typed, directed[row].want);
      quiesce();

      // fill every table entry that a read can reach
      for (k = 0; k < FILL_ENTRIES; k++) begin
         send(mk(CMD_LOAD, k[9:0], 16'($urandom_range(0, 65535)), rand_score(),
                 16'($signed($urandom_range(0, 1023)) - 512), rand_score()));
      end

      for (phase = 0; phase < 8; phase++) begin
         quiesce();
         write_reg(CSR_NORMALIZE, (phase == 7) ? 1 : $urandom_range(0, 1));
         write_reg(CSR_PRIOR, (phase == 6) ? 1 : $urandom_range(0, 1));
         write_reg(CSR_LENGTH, lengths[phase]);
         nvec = 48 / live_length();
         if (nvec < 1) nvec = 1;
         for (v = 0; v < nvec; v++) run_vector();
         // drain a finished vector before the length may change
         while (vec_ready) send(read_item());
      end

      req_tvalid <= 1'b0;
      wait_cycles = 0;
      while (expected_results.size() != 0 && wait_cycles < 100_000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_results.size() != 0) mismatches++;

      $display("covered %0d transfers in, %0d results, %0d full vectors read",
               accepted, received, vectors_done);
      $display("lengths 1 to 64 with zero acting as one, all enable settings, %0d mismatches",
               mismatches);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
